FILE: rtl/core/telnet_command_stream_parser_defines.svh
// ----------------------------------------------------------------------------
// Telnet command stream parser: assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TELNET_COMMAND_STREAM_PARSER_DEFINES_SVH
`define TELNET_COMMAND_STREAM_PARSER_DEFINES_SVH

// payload and valid hold while the receiver stalls
`define TCSP_ASSERT_HOLD(lbl, vld, stl, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && stl) |=> (vld && $stable(sig))) else $error("item changed under stall");

// combinational relation between port fields while an item is offered
`define TCSP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error("result fields inconsistent");

`endif

FILE: rtl/core/tcsp_pkg.sv
// ----------------------------------------------------------------------------
// tcsp_pkg
// Codes, sizes and shared types of the Telnet command stream parser.
// ----------------------------------------------------------------------------
package tcsp_pkg;

	// Telnet command codes
	localparam logic [7:0] TN_IAC  = 8'd255;
	localparam logic [7:0] TN_DONT = 8'd254;
	localparam logic [7:0] TN_DO   = 8'd253;
	localparam logic [7:0] TN_WONT = 8'd252;
	localparam logic [7:0] TN_WILL = 8'd251;
	localparam logic [7:0] TN_SB   = 8'd250;
	localparam logic [7:0] TN_SE   = 8'd240;

	// result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_CMD  = 2'd1;
	localparam logic [1:0] KIND_NEG  = 2'd2;
	localparam logic [1:0] KIND_SUB  = 2'd3;

	// subnegotiation buffer sizing; a run never exceeds MAX_RUN results
	localparam int SUB_DEPTH = 32;
	localparam int MAX_RUN   = 32;
	localparam int EFF_DEPTH = (SUB_DEPTH < MAX_RUN) ? SUB_DEPTH : MAX_RUN;
	localparam int ADDR_W    = $clog2(EFF_DEPTH);
	localparam int CNT_W     = $clog2(EFF_DEPTH + 1);

	// token queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       value;
		logic [1:0]       req;
		logic             empty;
		logic             ovf;
		logic [CNT_W-1:0] cnt;
	} tok_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} buf_wr_t;

	typedef struct packed {
		logic sub_done;
	} drain_t;

endpackage

FILE: rtl/core/telnet_command_stream_parser.sv
// ----------------------------------------------------------------------------
// telnet_command_stream_parser
// Splits a received Telnet byte stream into data, command, negotiation and
// subnegotiation results.
// ----------------------------------------------------------------------------
// A byte is taken when the queue has room and no wait below holds. Data,
// command and negotiation tokens give one result each; a subnegotiation with
// N buffered content bytes gives N results, one per cycle unless the output
// stalls, read from the content buffer (a single empty-marked result when N
// is zero). Results leave through the token queue and then a registered
// output stage. While an earlier subnegotiation is still queued or draining,
// the next subnegotiation's content bytes wait at the input, since the one
// content buffer is shared; the drain of N results sets that wait.
// ----------------------------------------------------------------------------
module telnet_command_stream_parser import tcsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] token_kind,
	output logic [7:0] token_value,
	output logic [1:0] request_code,
	output logic [7:0] content_byte,
	output logic       content_empty,
	output logic       content_overflow,
	output logic       last_of_run
);

	// front to queue
	logic    q_push, q_full;
	tok_t    q_tok;
	// queue to back
	logic    head_valid, q_pop;
	tok_t    head;
	// side paths: buffer writes forward, drain status back
	buf_wr_t buf_wr;
	drain_t  drain;

	// parser: phase tracking, content capture, token push
	tcsp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_tok    (q_tok),
		.buf_wr   (buf_wr),
		.drain    (drain)
	);

	// token FIFO so the parser keeps taking bytes while results wait
	tcsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_tok   (q_tok),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// sequencer: one result per cycle unless the output stalls, subnegotiation runs read the buffer
	tcsp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.buf_wr           (buf_wr),
		.head_valid       (head_valid),
		.head             (head),
		.pop              (q_pop),
		.drain            (drain),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.token_kind       (token_kind),
		.token_value      (token_value),
		.request_code     (request_code),
		.content_byte     (content_byte),
		.content_empty    (content_empty),
		.content_overflow (content_overflow),
		.last_of_run      (last_of_run)
	);

endmodule

FILE: rtl/core/tcsp_front.sv
// ----------------------------------------------------------------------------
// tcsp_front
// Byte parser: tracks the Telnet phase, writes subnegotiation content into
// the back end's buffer and pushes one token per finished construct.
// ----------------------------------------------------------------------------
module tcsp_front import tcsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       q_push,
	output tok_t       q_tok,
	output buf_wr_t    buf_wr,
	input  drain_t     drain
);

	localparam logic [2:0] PH_NORMAL  = 3'd0;
	localparam logic [2:0] PH_IAC     = 3'd1;
	localparam logic [2:0] PH_NEG     = 3'd2;
	localparam logic [2:0] PH_SUBOPT  = 3'd3;
	localparam logic [2:0] PH_SUBDATA = 3'd4;
	localparam logic [2:0] PH_SUBIAC  = 3'd5;

	logic [2:0]        phase_q, phase_d;
	logic [1:0]        req_q, req_d;
	logic [7:0]        opt_q, opt_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              ovf_q, ovf_d;
	logic [QCNT_W-1:0] subs_q;
	logic              accept, emit, store, in_sub;

	// content writes wait until every earlier subnegotiation run has drained
	assign in_sub   = (phase_q == PH_SUBDATA) || (phase_q == PH_SUBIAC);
	assign in_stall = q_full || (in_sub && (subs_q != '0));
	assign accept   = in_valid && !in_stall;

	always_comb begin
		phase_d = phase_q;
		req_d   = req_q;
		opt_d   = opt_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		emit    = 1'b0;
		store   = 1'b0;
		q_tok   = '0;
		unique case (phase_q)
			PH_IAC: begin
				phase_d = PH_NORMAL;
				priority if (rx_byte == TN_IAC) begin
					emit        = 1'b1;
					q_tok.kind  = KIND_DATA;
					q_tok.value = TN_IAC;
				end else if (rx_byte >= TN_WILL) begin
					req_d   = 2'(rx_byte - TN_WILL);
					phase_d = PH_NEG;
				end else if (rx_byte == TN_SB) begin
					phase_d = PH_SUBOPT;
				end else begin
					emit        = 1'b1;
					q_tok.kind  = KIND_CMD;
					q_tok.value = rx_byte;
				end
			end
			PH_NEG: begin
				emit        = 1'b1;
				q_tok.kind  = KIND_NEG;
				q_tok.value = rx_byte;
				q_tok.req   = req_q;
				phase_d     = PH_NORMAL;
			end
			PH_SUBOPT: begin
				opt_d   = rx_byte;
				cnt_d   = '0;
				ovf_d   = 1'b0;
				phase_d = PH_SUBDATA;
			end
			PH_SUBDATA: begin
				if (rx_byte == TN_IAC) begin
					phase_d = PH_SUBIAC;
				end else begin
					store = 1'b1;
				end
			end
			PH_SUBIAC: begin
				if (rx_byte == TN_SE) begin
					emit        = 1'b1;
					q_tok.kind  = KIND_SUB;
					q_tok.value = opt_q;
					q_tok.empty = (cnt_q == '0);
					q_tok.ovf   = ovf_q;
					q_tok.cnt   = cnt_q;
					phase_d     = PH_NORMAL;
				end else begin
					store   = 1'b1;
					phase_d = PH_SUBDATA;
				end
			end
			default: begin
				// normal phase; unused codes behave the same
				phase_d = PH_NORMAL;
				if (rx_byte == TN_IAC) begin
					phase_d = PH_IAC;
				end else begin
					emit        = 1'b1;
					q_tok.kind  = KIND_DATA;
					q_tok.value = rx_byte;
				end
			end
		endcase
		if (store) begin
			if (cnt_q < CNT_W'(EFF_DEPTH)) begin
				cnt_d = cnt_q + 1'b1;
			end else begin
				ovf_d = 1'b1;
			end
		end
	end

	assign q_push      = accept && emit;
	assign buf_wr.en   = accept && store && (cnt_q < CNT_W'(EFF_DEPTH));
	assign buf_wr.addr = cnt_q[ADDR_W-1:0];
	assign buf_wr.data = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			req_q   <= '0;
			opt_q   <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			req_q   <= req_d;
			opt_q   <= opt_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

	// subnegotiation tokens queued or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subs_q <= '0;
		end else begin
			unique case ({q_push && (q_tok.kind == KIND_SUB), drain.sub_done})
				2'b10:   subs_q <= subs_q + 1'b1;
				2'b01:   subs_q <= subs_q - 1'b1;
				default: subs_q <= subs_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/tcsp_queue.sv
// ----------------------------------------------------------------------------
// tcsp_queue
// Short token FIFO that decouples the parser from the result sequencer.
// ----------------------------------------------------------------------------
module tcsp_queue import tcsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tok_t push_tok,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output tok_t head
);

	tok_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QPTR_W'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == QPTR_W'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/tcsp_back.sv
// ----------------------------------------------------------------------------
// tcsp_back
// Result sequencer: holds the subnegotiation buffer, expands each token into
// its results and drives the registered output stage.
// ----------------------------------------------------------------------------
module tcsp_back import tcsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  buf_wr_t    buf_wr,
	input  logic       head_valid,
	input  tok_t       head,
	output logic       pop,
	output drain_t     drain,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] token_kind,
	output logic [7:0] token_value,
	output logic [1:0] request_code,
	output logic [7:0] content_byte,
	output logic       content_empty,
	output logic       content_overflow,
	output logic       last_of_run
);

	logic [7:0]        buf_mem [EFF_DEPTH];
	logic [ADDR_W-1:0] idx_q;
	logic              adv, multi, last;

	logic              vld_s2;
	logic [1:0]        kind_s2, req_s2;
	logic [7:0]        value_s2, rd_s2;
	logic              empty_s2, ovf_s2, last_s2, use_mem_s2;

	assign multi = (head.kind == KIND_SUB) && !head.empty;
	assign last  = !multi || ((CNT_W'(idx_q) + 1'b1) == head.cnt);
	assign adv   = head_valid && (!vld_s2 || !out_stall);
	assign pop   = adv && last;

	assign drain.sub_done = pop && (head.kind == KIND_SUB);

	always_ff @(posedge clk) begin
		if (buf_wr.en) begin
			buf_mem[buf_wr.addr] <= buf_wr.data;
		end
	end

	// read data and payload move together into the output stage
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s2      <= buf_mem[idx_q];
			kind_s2    <= head.kind;
			value_s2   <= head.value;
			req_s2     <= head.req;
			empty_s2   <= head.empty;
			ovf_s2     <= head.ovf;
			last_s2    <= last;
			use_mem_s2 <= multi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (adv) begin
				vld_s2 <= 1'b1;
				idx_q  <= last ? '0 : idx_q + 1'b1;
			end else if (!out_stall) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	assign out_valid        = vld_s2;
	assign token_kind       = kind_s2;
	assign token_value      = value_s2;
	assign request_code     = req_s2;
	assign content_byte     = use_mem_s2 ? rd_s2 : 8'd0;
	assign content_empty    = empty_s2;
	assign content_overflow = ovf_s2;
	assign last_of_run      = last_s2;

endmodule

FILE: rtl/core/tcsp_checker.sv
// ----------------------------------------------------------------------------
// tcsp_checker
// Port-level checks on the parser's input and result channels.
// ----------------------------------------------------------------------------
`include "telnet_command_stream_parser_defines.svh"

module tcsp_checker import tcsp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] token_kind,
	input logic [7:0] token_value,
	input logic [1:0] request_code,
	input logic [7:0] content_byte,
	input logic       content_empty,
	input logic       content_overflow,
	input logic       last_of_run
);

	`TCSP_ASSERT_HOLD(a_in_hold, in_valid, in_stall, rx_byte)
	`TCSP_ASSERT_HOLD(a_out_hold, out_valid, out_stall, {token_kind, token_value, content_byte, last_of_run})
	`TCSP_ASSERT_IMPL(a_req_only_neg, out_valid && (token_kind != KIND_NEG), request_code == 2'd0)
	`TCSP_ASSERT_IMPL(a_empty_sub, out_valid && content_empty, (token_kind == KIND_SUB) && (content_byte == 8'd0) && last_of_run)
	`TCSP_ASSERT_IMPL(a_single_nonsub, out_valid && (token_kind != KIND_SUB), last_of_run && !content_overflow && !content_empty)

endmodule

bind telnet_command_stream_parser tcsp_checker u_tcsp_checker (.*);
